>>> rtl/xwdg_pkg.sv
// Shared types and constants for the XWD to gray stream converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package xwdg_pkg;

	localparam int DIM_W        = 15;
	localparam int MAX_DIM      = 16384;
	localparam int HEADER_BYTES = 100;

	typedef enum logic [1:0] {
		KIND_HDR  = 2'd0,
		KIND_PIX  = 2'd1,
		KIND_STAT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BAD   = 2'd1,
		ST_SHORT = 2'd2
	} status_t;

	// One queue entry: everything a single input byte causes on the output.
	typedef struct packed {
		logic             hdr;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             pix;
		logic [7:0]       gray;
		logic             stat;
		status_t          status;
	} desc_t;

endpackage

>>> rtl/xwd_to_gray_stream_converter.sv
// Top level of the XWD to 8-bit gray stream converter.
// Depends on xwdg_pkg, xwdg_parser, xwdg_fifo and xwdg_out_seq.
//
// Input channel (in_valid/in_ready): one byte of the dump per beat, in_last on
// the final byte. Output channel (out_valid/out_ready): header bytes
// (out_kind 0), gray pixels (out_kind 1) and one status beat (out_kind 2,
// out_last 1) after the byte marked in_last.
// Throughput: one input byte per cycle. The parser stage takes a byte every
// cycle unless the entry queue (FIFO_DEPTH entries) is full; a pixel or status
// entry leaves as one beat, the header entry as twelve beats, and an entry
// that also carries the status adds one beat more.
// Path: a result reaches the output through the parser register, the queue
// and then the result register, behind any beats queued ahead of it.
// When the receiver stalls, the result register holds its beat, the queue
// fills, and in_ready drops once the queue is full with a byte waiting in the
// parser register.
// Reset clears the parser state, the queue and the result register; the
// block then waits for the first header byte. After each byte marked in_last
// the parser is back in its reset state for the next dump.
`timescale 1ns / 1ps

module xwd_to_gray_stream_converter #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic [1:0] out_status,
	output logic       out_last
);
	import xwdg_pkg::*;

	logic  push, pop, empty, full;
	desc_t push_desc, head;

	xwdg_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.fifo_full (full),
		.push      (push),
		.push_desc (push_desc)
	);

	xwdg_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_desc),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty),
		.full   (full)
	);

	xwdg_out_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_kind   (out_kind),
		.out_status (out_status),
		.out_last   (out_last)
	);

endmodule

>>> rtl/xwdg_parser.sv
// Input register and dump parser: header checks, skip, colormap, pixel luma.
// Depends on xwdg_pkg; produces one queue entry per byte that has output.
`timescale 1ns / 1ps

module xwdg_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	input  logic           fifo_full,
	output logic           push,
	output xwdg_pkg::desc_t push_desc
);
	import xwdg_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_CMAP,
		PH_PIXELS,
		PH_DONE,
		PH_ERROR
	} phase_t;

	// header word positions, taken at the last byte of each word
	localparam logic [6:0] OFF_HSIZE   = 7'd3;
	localparam logic [6:0] OFF_VERSION = 7'd7;
	localparam logic [6:0] OFF_FORMAT  = 7'd11;
	localparam logic [6:0] OFF_DEPTH   = 7'd15;
	localparam logic [6:0] OFF_WIDTH   = 7'd19;
	localparam logic [6:0] OFF_HEIGHT  = 7'd23;
	localparam logic [6:0] OFF_BORDER  = 7'd31;
	localparam logic [6:0] OFF_BPP     = 7'd47;
	localparam logic [6:0] OFF_STRIDE  = 7'd51;
	localparam logic [6:0] OFF_RMASK   = 7'd59;
	localparam logic [6:0] OFF_GMASK   = 7'd63;
	localparam logic [6:0] OFF_BMASK   = 7'd67;
	localparam logic [6:0] OFF_NCMAP   = 7'd79;
	localparam logic [6:0] OFF_HDR_END = 7'(HEADER_BYTES - 1);

	localparam logic [15:0] COEF_R = 16'd77;
	localparam logic [15:0] COEF_G = 16'd150;
	localparam logic [15:0] COEF_B = 16'd29;

	logic             s1_valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             stall;
	logic             fire;

	phase_t           phase_q, phase_d;
	logic [31:0]      pos_q, pos_d;
	logic [23:0]      shift_q, shift_d;
	logic [31:0]      hlen_q, hlen_d;
	logic [DIM_W-1:0] width_q, width_d;
	logic [DIM_W-1:0] height_q, height_d;
	logic [31:0]      stride_q, stride_d;
	logic [31:0]      cmap_q, cmap_d;
	logic             lok_q, lok_d;
	logic [31:0]      rbi_q, rbi_d;
	logic [DIM_W-1:0] row_q, row_d;
	logic [15:0]      part_q, part_d;

	logic [31:0]      word;
	logic             hdr, pix, stat;
	logic [7:0]       gray;
	status_t          st;

	assign stall    = s1_valid_s1 && fifo_full;
	assign fire     = s1_valid_s1 && !stall;
	assign in_ready = !stall;
	assign word     = {shift_q, byte_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!stall) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		shift_d  = shift_q;
		hlen_d   = hlen_q;
		width_d  = width_q;
		height_d = height_q;
		stride_d = stride_q;
		cmap_d   = cmap_q;
		lok_d    = lok_q;
		rbi_d    = rbi_q;
		row_d    = row_q;
		part_d   = part_q;
		hdr      = 1'b0;
		pix      = 1'b0;
		stat     = 1'b0;
		gray     = 8'd0;
		st       = ST_OK;

		unique case (phase_q)
			PH_HEADER: begin
				shift_d = word[23:0];
				if (pos_q[1:0] == 2'd3) begin
					case (pos_q[6:0])
						OFF_HSIZE: begin
							if (word < 32'(HEADER_BYTES)) lok_d = 1'b0;
							hlen_d = word;
						end
						OFF_VERSION: if (word != 32'd7) lok_d = 1'b0;
						OFF_FORMAT:  if (word != 32'd2) lok_d = 1'b0;
						OFF_DEPTH:   if (word != 32'd24 && word != 32'd32) lok_d = 1'b0;
						OFF_WIDTH: begin
							if (word == 32'd0 || word > 32'(MAX_DIM)) begin
								lok_d   = 1'b0;
								width_d = '0;
							end else begin
								width_d = word[DIM_W-1:0];
							end
						end
						OFF_HEIGHT: begin
							if (word == 32'd0 || word > 32'(MAX_DIM)) begin
								lok_d    = 1'b0;
								height_d = '0;
							end else begin
								height_d = word[DIM_W-1:0];
							end
						end
						OFF_BORDER: if (word != 32'd0 && word != 32'd43) lok_d = 1'b0;
						OFF_BPP:    if (word != 32'd32) lok_d = 1'b0;
						OFF_STRIDE: begin
							if (word < 32'({width_q, 2'b00})) lok_d = 1'b0;
							stride_d = word;
						end
						OFF_RMASK: if (word[23:0] != 24'hff0000) lok_d = 1'b0;
						OFF_GMASK: if (word[23:0] != 24'h00ff00) lok_d = 1'b0;
						OFF_BMASK: if (word[23:0] != 24'h0000ff) lok_d = 1'b0;
						OFF_NCMAP: cmap_d = word;
						default: ;
					endcase
				end
				if (pos_q[6:0] == OFF_HDR_END) begin
					if (!lok_d) begin
						phase_d = PH_ERROR;
					end else begin
						hdr = 1'b1;
						if (hlen_d > 32'(HEADER_BYTES)) begin
							phase_d = PH_SKIP;
						end else begin
							rbi_d   = '0;
							row_d   = '0;
							phase_d = (cmap_d != 32'd0) ? PH_CMAP : PH_PIXELS;
						end
					end
				end
				pos_d = pos_q + 32'd1;
			end
			PH_SKIP: begin
				if (pos_q == hlen_q - 32'd1) begin
					rbi_d   = '0;
					row_d   = '0;
					phase_d = (cmap_q != 32'd0) ? PH_CMAP : PH_PIXELS;
				end
				pos_d = pos_q + 32'd1;
			end
			PH_CMAP: begin
				// 12 bytes per colormap entry
				if (rbi_q == 32'd11) begin
					rbi_d  = '0;
					cmap_d = cmap_q - 32'd1;
					if (cmap_d == 32'd0) begin
						row_d   = '0;
						phase_d = PH_PIXELS;
					end
				end else begin
					rbi_d = rbi_q + 32'd1;
				end
			end
			PH_PIXELS: begin
				if (rbi_q < 32'({width_q, 2'b00})) begin
					case (rbi_q[1:0])
						2'd0: part_d = 16'(byte_s1) * COEF_B;
						2'd1: part_d = part_q + 16'(byte_s1) * COEF_G;
						2'd2: part_d = part_q + 16'(byte_s1) * COEF_R;
						default: begin
							pix  = 1'b1;
							gray = part_q[15:8];
						end
					endcase
				end
				// rbi_q < stride_q here, so the increment cannot wrap
				if (rbi_q + 32'd1 >= stride_q) begin
					rbi_d = '0;
					row_d = row_q + 1'b1;
					if (row_d >= height_q) phase_d = PH_DONE;
				end else begin
					rbi_d = rbi_q + 32'd1;
				end
			end
			default: ;
		endcase

		if (last_s1) begin
			stat = 1'b1;
			if (phase_d == PH_DONE)        st = ST_OK;
			else if (phase_d == PH_HEADER) st = ST_SHORT;
			else                           st = ST_BAD;
			phase_d  = PH_HEADER;
			pos_d    = '0;
			shift_d  = '0;
			hlen_d   = '0;
			width_d  = '0;
			height_d = '0;
			stride_d = '0;
			cmap_d   = '0;
			lok_d    = 1'b1;
			rbi_d    = '0;
			row_d    = '0;
			part_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			shift_q  <= '0;
			hlen_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			stride_q <= '0;
			cmap_q   <= '0;
			lok_q    <= 1'b1;
			rbi_q    <= '0;
			row_q    <= '0;
			part_q   <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			shift_q  <= shift_d;
			hlen_q   <= hlen_d;
			width_q  <= width_d;
			height_q <= height_d;
			stride_q <= stride_d;
			cmap_q   <= cmap_d;
			lok_q    <= lok_d;
			rbi_q    <= rbi_d;
			row_q    <= row_d;
			part_q   <= part_d;
		end
	end

	// header sizes come from the registers: a last beat clears the next state
	assign push             = fire && (hdr || pix || stat);
	assign push_desc.hdr    = hdr;
	assign push_desc.width  = width_q;
	assign push_desc.height = height_q;
	assign push_desc.pix    = pix;
	assign push_desc.gray   = gray;
	assign push_desc.stat   = stat;
	assign push_desc.status = st;

endmodule

>>> rtl/xwdg_fifo.sv
// Queue of output entries between the parser and the output sequencer.
// Depends on xwdg_pkg for the entry type.
`timescale 1ns / 1ps

module xwdg_fifo #(
	parameter int DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  xwdg_pkg::desc_t wdata,
	input  logic            pop,
	output xwdg_pkg::desc_t rdata,
	output logic            empty,
	output logic            full
);
	import xwdg_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t            mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rdata = mem[rd_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));

endmodule

>>> rtl/xwdg_out_seq.sv
// Output sequencer: expands queue entries into beats on the result register.
// Depends on xwdg_pkg; a header entry becomes twelve beats.
`timescale 1ns / 1ps

module xwdg_out_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  xwdg_pkg::desc_t head,
	input  logic            empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic [1:0]      out_kind,
	output logic [1:0]      out_status,
	output logic            out_last
);
	import xwdg_pkg::*;

	localparam logic [3:0] HDR_LAST = 4'd11;

	function automatic logic [7:0] hdr_byte(
		input logic [3:0]       idx,
		input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h
	);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = 8'h53;
			4'd1:    b = 8'h4C;
			4'd2:    b = 8'h47;
			4'd3:    b = 8'h57;
			4'd6:    b = 8'(w >> 8);
			4'd7:    b = w[7:0];
			4'd10:   b = 8'(h >> 8);
			4'd11:   b = h[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	logic       valid_q;
	logic [7:0] byte_q;
	kind_t      kind_q;
	status_t    status_q;
	logic       last_q;
	logic [3:0] idx_q;

	logic       load;
	logic       final_item;
	logic [7:0] nxt_byte;
	kind_t      nxt_kind;
	status_t    nxt_status;
	logic       nxt_last;

	always_comb begin
		nxt_byte   = 8'd0;
		nxt_kind   = KIND_STAT;
		nxt_status = head.status;
		nxt_last   = 1'b1;
		final_item = 1'b1;
		if (head.hdr && idx_q <= HDR_LAST) begin
			nxt_byte   = hdr_byte(idx_q, head.width, head.height);
			nxt_kind   = KIND_HDR;
			nxt_status = ST_OK;
			nxt_last   = 1'b0;
			final_item = !head.stat && (idx_q == HDR_LAST);
		end else if (head.pix && idx_q == 4'd0) begin
			nxt_byte   = head.gray;
			nxt_kind   = KIND_PIX;
			nxt_status = ST_OK;
			nxt_last   = 1'b0;
			final_item = !head.stat;
		end
	end

	assign load = !empty && (!valid_q || out_ready);
	assign pop  = load && final_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load)           valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			if (load) idx_q <= final_item ? 4'd0 : idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= nxt_byte;
			kind_q   <= nxt_kind;
			status_q <= nxt_status;
			last_q   <= nxt_last;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign out_kind   = kind_q;
	assign out_status = status_q;
	assign out_last   = last_q;

endmodule

>>> rtl/xwdg_checker.sv
// Port-level checks on the converter's output channel, bound to the top level.
// Depends on xwdg_pkg and xwd_to_gray_stream_converter.
`timescale 1ns / 1ps

module xwdg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [1:0] out_kind,
	input logic [1:0] out_status,
	input logic       out_last
);
	import xwdg_pkg::*;

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind)
			&& $stable(out_status) && $stable(out_last))
		else $error("output beat changed while stalled");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_kind == KIND_STAT)))
		else $error("out_last does not match status beat");

	a_data_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_STAT |-> out_status == ST_OK)
		else $error("data beat carries a status");

	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_STAT |-> out_byte == 8'd0
			&& (out_status == ST_OK || out_status == ST_BAD || out_status == ST_SHORT))
		else $error("malformed status beat");

	// a new dump cannot produce a pixel straight after the status beat
	a_no_pix_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !(out_valid && out_kind == KIND_PIX))
		else $error("pixel beat directly after status beat");

endmodule

bind xwd_to_gray_stream_converter xwdg_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.out_kind   (out_kind),
	.out_status (out_status),
	.out_last   (out_last)
);

>>> tb/sv/tb_xwd_to_gray_stream_converter.sv
// Self-checking testbench for xwd_to_gray_stream_converter: builds XWD dumps, streams
// them in byte by byte and checks every output beat against its own decoder model.
// Depends on xwdg_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_xwd_to_gray_stream_converter;
	import xwdg_pkg::*;

	localparam int     CLK_PERIOD      = 20;
	localparam int     RESET_CYCLES    = 11;
	localparam longint WATCHDOG_CYCLES = 3_000_000;
	localparam int     DRAIN_LIMIT     = 200_000;
	localparam int     SETTLE_CYCLES   = 20;
	localparam int     HOLD_CYCLES     = 400;

	// byte offsets of the header words that matter
	localparam int OFF_HSIZE      = 0;
	localparam int OFF_VERSION    = 4;
	localparam int OFF_FORMAT     = 8;
	localparam int OFF_DEPTH      = 12;
	localparam int OFF_WIDTH      = 16;
	localparam int OFF_HEIGHT     = 20;
	localparam int OFF_BYTE_ORDER = 28;
	localparam int OFF_BPP        = 44;
	localparam int OFF_STRIDE     = 48;
	localparam int OFF_RED        = 56;
	localparam int OFF_GREEN      = 60;
	localparam int OFF_BLUE       = 64;
	localparam int OFF_NCOLORS    = 76;
	localparam int HDR_WORDS      = HEADER_BYTES / 4;

	localparam logic [31:0] XWD_VERSION = 32'd7;
	localparam logic [31:0] ZPIXMAP     = 32'd2;
	localparam logic [31:0] DEPTH_24    = 32'd24;
	localparam logic [31:0] DEPTH_32    = 32'd32;
	localparam logic [31:0] ORDER_LSB   = 32'd0;
	localparam logic [31:0] ORDER_MSB   = 32'd43;
	localparam logic [31:0] BPP_32      = 32'd32;
	localparam logic [31:0] RED_MASK    = 32'h00ff0000;
	localparam logic [31:0] GREEN_MASK  = 32'h0000ff00;
	localparam logic [31:0] BLUE_MASK   = 32'h000000ff;
	localparam logic [31:0] RGB_BITS    = 32'h00ffffff;
	localparam int          CMAP_ENTRY_BYTES = 12;
	localparam logic [7:0]  MAGIC [4] = '{8'h53, 8'h4c, 8'h47, 8'h57};
	localparam logic [15:0] LUMA_R = 16'd77;
	localparam logic [15:0] LUMA_G = 16'd150;
	localparam logic [15:0] LUMA_B = 16'd29;

	typedef enum logic [2:0] {
		DEC_HEADER, DEC_SKIP, DEC_CMAP, DEC_PIXELS, DEC_DONE, DEC_ERROR
	} dec_phase_t;

	typedef struct {
		logic [7:0] value;
		kind_t      kind;
		status_t    status;
		logic       last;
	} gray_beat_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic [1:0] out_status;
	logic       out_last;

	// decoder model state
	dec_phase_t   dec_phase;
	logic [31:0]  byte_pos;
	logic [31:0]  word_acc;
	logic [31:0]  hdr_len;
	logic [14:0]  img_width;
	logic [14:0]  img_height;
	logic [31:0]  line_stride;
	logic [31:0]  cmap_left;
	logic         layout_good;
	logic [31:0]  row_pos;
	logic [14:0]  row_count;
	logic [15:0]  luma_acc;

	gray_beat_t   pending_beats [$];
	logic [7:0]   dump_bytes [$];
	logic [31:0]  hdr_words [HDR_WORDS];
	int           error_count = 0;
	bit           tx_idle_on = 1'b1;
	int           rx_hold_left = 0;
	int           rx_gap_left = 0;

	xwd_to_gray_stream_converter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_kind  (out_kind),
		.out_status(out_status),
		.out_last  (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ---------------------------------------------------------------- decoder model

	function automatic void reset_decoder();
		dec_phase   = DEC_HEADER;
		byte_pos    = '0;
		word_acc    = '0;
		hdr_len     = '0;
		img_width   = '0;
		img_height  = '0;
		line_stride = '0;
		cmap_left   = '0;
		layout_good = 1'b1;
		row_pos     = '0;
		row_count   = '0;
		luma_acc    = '0;
	endfunction

	function automatic void push_beat(input logic [7:0] value, input kind_t kind,
			input status_t status, input logic last);
		gray_beat_t beat;
		beat.value  = value;
		beat.kind   = kind;
		beat.status = status;
		beat.last   = last;
		pending_beats.push_back(beat);
	endfunction

	function automatic void check_header_word(input logic [31:0] off, input logic [31:0] w);
		case (off)
		OFF_HSIZE: begin
			if (w < HEADER_BYTES) layout_good = 1'b0;
			hdr_len = w;
		end
		OFF_VERSION: if (w != XWD_VERSION) layout_good = 1'b0;
		OFF_FORMAT:  if (w != ZPIXMAP) layout_good = 1'b0;
		OFF_DEPTH:   if (w != DEPTH_24 && w != DEPTH_32) layout_good = 1'b0;
		OFF_WIDTH: begin
			if (w == 0 || w > MAX_DIM) begin
				layout_good = 1'b0;
				img_width   = '0;
			end else begin
				img_width = w[14:0];
			end
		end
		OFF_HEIGHT: begin
			if (w == 0 || w > MAX_DIM) begin
				layout_good = 1'b0;
				img_height  = '0;
			end else begin
				img_height = w[14:0];
			end
		end
		OFF_BYTE_ORDER: if (w != ORDER_LSB && w != ORDER_MSB) layout_good = 1'b0;
		OFF_BPP:        if (w != BPP_32) layout_good = 1'b0;
		OFF_STRIDE: begin
			if (w < 32'(img_width) * 32'd4) layout_good = 1'b0;
			line_stride = w;
		end
		OFF_RED:     if ((w & RGB_BITS) != RED_MASK) layout_good = 1'b0;
		OFF_GREEN:   if ((w & RGB_BITS) != GREEN_MASK) layout_good = 1'b0;
		OFF_BLUE:    if ((w & RGB_BITS) != BLUE_MASK) layout_good = 1'b0;
		OFF_NCOLORS: cmap_left = w;
		default: ;
		endcase
	endfunction

	function automatic void enter_body();
		row_pos   = '0;
		row_count = '0;
		dec_phase = (cmap_left != 0) ? DEC_CMAP : DEC_PIXELS;
	endfunction

	// Works out every beat that one accepted input byte causes.
	function automatic void predict_byte(input logic [7:0] b, input logic last);
		status_t st;
		case (dec_phase)
		DEC_HEADER: begin
			word_acc = {word_acc[23:0], b};
			if (byte_pos[1:0] == 2'd3) check_header_word(byte_pos - 32'd3, word_acc);
			if (byte_pos == HEADER_BYTES - 1) begin
				if (!layout_good) begin
					dec_phase = DEC_ERROR;
				end else begin
					for (int i = 0; i < 4; i++) push_beat(MAGIC[i], KIND_HDR, ST_OK, 1'b0);
					push_beat(8'h00, KIND_HDR, ST_OK, 1'b0);
					push_beat(8'h00, KIND_HDR, ST_OK, 1'b0);
					push_beat(8'(img_width >> 8), KIND_HDR, ST_OK, 1'b0);
					push_beat(img_width[7:0], KIND_HDR, ST_OK, 1'b0);
					push_beat(8'h00, KIND_HDR, ST_OK, 1'b0);
					push_beat(8'h00, KIND_HDR, ST_OK, 1'b0);
					push_beat(8'(img_height >> 8), KIND_HDR, ST_OK, 1'b0);
					push_beat(img_height[7:0], KIND_HDR, ST_OK, 1'b0);
					if (hdr_len > HEADER_BYTES) dec_phase = DEC_SKIP;
					else enter_body();
				end
			end
			byte_pos++;
		end
		DEC_SKIP: begin
			if (byte_pos == hdr_len - 32'd1) enter_body();
			byte_pos++;
		end
		DEC_CMAP: begin
			if (row_pos == CMAP_ENTRY_BYTES - 1) begin
				row_pos = '0;
				cmap_left--;
				if (cmap_left == 0) enter_body();
			end else begin
				row_pos++;
			end
		end
		DEC_PIXELS: begin
			// bytes come B, G, R, X; padding past width*4 is dropped
			if (row_pos < 32'(img_width) * 32'd4) begin
				case (row_pos[1:0])
				2'd0: luma_acc = LUMA_B * b;
				2'd1: luma_acc = luma_acc + LUMA_G * b;
				2'd2: luma_acc = luma_acc + LUMA_R * b;
				default: push_beat(luma_acc[15:8], KIND_PIX, ST_OK, 1'b0);
				endcase
			end
			if (row_pos + 32'd1 >= line_stride) begin
				row_pos = '0;
				row_count++;
				if (row_count >= img_height) dec_phase = DEC_DONE;
			end else begin
				row_pos++;
			end
		end
		default: ;
		endcase

		if (last) begin
			if (dec_phase == DEC_DONE) st = ST_OK;
			else if (dec_phase == DEC_HEADER) st = ST_SHORT;
			else st = ST_BAD;
			push_beat(8'h00, KIND_STAT, st, 1'b1);
			reset_decoder();
		end
	endfunction

	// ---------------------------------------------------------------- dump building

	function automatic void push_random(input longint unsigned count);
		for (longint unsigned i = 0; i < count; i++) dump_bytes.push_back(8'($urandom));
	endfunction

	function automatic void push_pixel(input logic [7:0] b, g, r, x);
		dump_bytes.push_back(b);
		dump_bytes.push_back(g);
		dump_bytes.push_back(r);
		dump_bytes.push_back(x);
	endfunction

	// Valid header words; free choices and ignored words are random.
	function automatic void build_header(input logic [31:0] w, h, stride, ncolors, hlen);
		foreach (hdr_words[i]) hdr_words[i] = $urandom;
		hdr_words[OFF_HSIZE / 4]      = hlen;
		hdr_words[OFF_VERSION / 4]    = XWD_VERSION;
		hdr_words[OFF_FORMAT / 4]     = ZPIXMAP;
		hdr_words[OFF_DEPTH / 4]      = $urandom_range(0, 1) ? DEPTH_24 : DEPTH_32;
		hdr_words[OFF_WIDTH / 4]      = w;
		hdr_words[OFF_HEIGHT / 4]     = h;
		hdr_words[OFF_BYTE_ORDER / 4] = $urandom_range(0, 1) ? ORDER_LSB : ORDER_MSB;
		hdr_words[OFF_BPP / 4]        = BPP_32;
		hdr_words[OFF_STRIDE / 4]     = stride;
		hdr_words[OFF_RED / 4]        = RED_MASK | ($urandom & ~RGB_BITS);
		hdr_words[OFF_GREEN / 4]      = GREEN_MASK | ($urandom & ~RGB_BITS);
		hdr_words[OFF_BLUE / 4]       = BLUE_MASK | ($urandom & ~RGB_BITS);
		hdr_words[OFF_NCOLORS / 4]    = ncolors;
	endfunction

	function automatic void push_header();
		foreach (hdr_words[i]) begin
			dump_bytes.push_back(hdr_words[i][31:24]);
			dump_bytes.push_back(hdr_words[i][23:16]);
			dump_bytes.push_back(hdr_words[i][15:8]);
			dump_bytes.push_back(hdr_words[i][7:0]);
		end
	endfunction

	function automatic void assemble_dump(input int unsigned skip, ncolors, stride, h);
		push_header();
		push_random(skip);
		push_random(ncolors * CMAP_ENTRY_BYTES);
		push_random(stride * h);
	endfunction

	function automatic void build_good_dump(input int unsigned w, h, stride, ncolors, hlen);
		build_header(w, h, stride, ncolors, hlen);
		assemble_dump(hlen - HEADER_BYTES, ncolors, stride, h);
	endfunction

	// ---------------------------------------------------------------- handshakes

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic last);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte  <= value;
		in_last  <= last;
		do @(posedge clk); while (!in_ready);
		predict_byte(value, last);
	endtask

	// Sends the first count bytes (all if zero) with in_last on the final one.
	task automatic send_dump(input int unsigned count);
		int unsigned n;
		n = (count == 0 || count > dump_bytes.size()) ? dump_bytes.size() : count;
		for (int unsigned i = 0; i < n; i++) send_byte(dump_bytes[i], i == n - 1);
		dump_bytes.delete();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold when a test asks for one
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				out_ready <= 1'b0;
				rx_hold_left--;
			end else if (rx_gap_left > 0) begin
				out_ready <= 1'b0;
				rx_gap_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) rx_gap_left = pick_gap();
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want, got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : beat_checker
		gray_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				$error("beat with nothing expected: out_byte %0h out_kind %0d", out_byte,
					out_kind);
				error_count++;
			end else begin
				want = pending_beats.pop_front();
				check_field("out_byte", want.value, out_byte);
				check_field("out_kind", 8'(want.kind), 8'(out_kind));
				check_field("out_status", 8'(want.status), 8'(out_status));
				check_field("out_last", 8'(want.last), 8'(out_last));
			end
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_short_input();
		// input ends part way through the header
		build_good_dump(2, 2, 8, 0, HEADER_BYTES);
		send_dump(57);
	endtask

	task automatic test_bad_layout();
		int unsigned pick;
		pick = $urandom_range(0, 13);
		build_header(2, 2, 8, 0, HEADER_BYTES);
		case (pick)
		0:  hdr_words[OFF_HSIZE / 4]      = HEADER_BYTES - 1;
		1:  hdr_words[OFF_VERSION / 4]    = XWD_VERSION - 1;
		2:  hdr_words[OFF_FORMAT / 4]     = ZPIXMAP - 1;
		3:  hdr_words[OFF_DEPTH / 4]      = 32'd16;
		4:  hdr_words[OFF_WIDTH / 4]      = 32'd0;
		5:  hdr_words[OFF_WIDTH / 4]      = MAX_DIM + 1;
		6:  hdr_words[OFF_HEIGHT / 4]     = 32'd0;
		7:  hdr_words[OFF_HEIGHT / 4]     = MAX_DIM + 1;
		8:  hdr_words[OFF_BYTE_ORDER / 4] = 32'd1;
		9:  hdr_words[OFF_BPP / 4]        = 32'd24;
		10: hdr_words[OFF_STRIDE / 4]     = 32'd7;
		11: hdr_words[OFF_RED / 4]        = GREEN_MASK;
		12: hdr_words[OFF_GREEN / 4]      = BLUE_MASK;
		default: hdr_words[OFF_BLUE / 4]  = RED_MASK;
		endcase
		// rejected header ending right on its last byte
		push_header();
		send_dump(0);
	endtask

	task automatic test_large_sizes();
		// largest image, longest header skip and colormap; input stops after the header
		build_header(MAX_DIM, MAX_DIM, MAX_DIM * 4, 32'hffffffff, 32'hffffffff);
		push_header();
		send_dump(0);
	endtask

	task automatic test_skip_and_colormap();
		// odd header length, one colormap entry, one pad byte per row, a trailing byte
		build_good_dump(1, 1, 5, 1, HEADER_BYTES + 1);
		push_random(1);
		send_dump(0);
	endtask

	task automatic test_back_pressure();
		// receiver holds off while bytes keep coming, so the queue fills;
		// the first pixels cover the luma extremes
		tx_idle_on = 1'b0;
		build_header(4, 4, 16, 0, HEADER_BYTES);
		push_header();
		push_pixel(8'hff, 8'hff, 8'hff, 8'hff);
		push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		push_pixel(8'h00, 8'h00, 8'hff, 8'h00);
		push_pixel(8'h00, 8'hff, 8'h00, 8'h00);
		push_pixel(8'hff, 8'h00, 8'h00, 8'hff);
		push_pixel(8'h12, 8'h34, 8'h56, 8'h78);
		push_pixel(8'hff, 8'h00, 8'hff, 8'h00);
		push_pixel(8'h80, 8'h80, 8'h80, 8'h80);
		push_random(32);
		rx_hold_left = HOLD_CYCLES;
		send_dump(0);
		tx_idle_on = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : stimulus
		int drain_cycles;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_byte  = 8'h00;
		in_last  = 1'b0;
		reset_decoder();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_short_input();
		test_bad_layout();
		test_large_sizes();
		test_skip_and_colormap();
		test_back_pressure();

		drain_cycles = 0;
		while (pending_beats.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_beats.size() != 0) begin
			$error("%0d expected beats never arrived", pending_beats.size());
			error_count++;
		end
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * WATCHDOG_CYCLES);
		$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/xwdg_pkg.sv
rtl/xwdg_parser.sv
rtl/xwdg_fifo.sv
rtl/xwdg_out_seq.sv
rtl/xwd_to_gray_stream_converter.sv
rtl/xwdg_checker.sv
tb/sv/tb_xwd_to_gray_stream_converter.sv
